@@ hw/rtl/adec_pkg.sv @@
// Package with the character codes, status codes and shared types of the calculator.
`default_nettype none

package adec_pkg;

  localparam int unsigned PREFIX_LEN_DEF = 5;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2a;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2f;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADOP   = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    logic [CHAR_W-1:0]  op;
    logic               ready;
  } calc_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic                err;
  } emit_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/adec_parse.sv @@
// Command parser: prefix skip, operand accumulation and operator capture.
`default_nettype none

module adec_parse
  import adec_pkg::*;
#(
  parameter int unsigned PREFIX_LEN = PREFIX_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_accept,
  input  wire logic [CHAR_W-1:0] in_char,
  output calc_req_t              req,
  output logic                   req_valid
);

  typedef enum logic [2:0] {PH_PREFIX, PH_FIRST, PH_OP, PH_SKIP, PH_SECOND} phase_t;

  localparam logic [3:0] PFX_LEN = 4'(PREFIX_LEN);
  localparam phase_t PH_START = (PFX_LEN == 4'd0) ? PH_FIRST : PH_PREFIX;

  phase_t             phase;
  logic [3:0]         skip_count;
  logic [VALUE_W-1:0] first_value;
  logic [VALUE_W-1:0] second_value;
  logic [CHAR_W-1:0]  op_code;
  logic [3:0]         skip_count_next;

  function automatic logic [VALUE_W-1:0] accumulate(input logic [VALUE_W-1:0] acc,
                                                    input logic [CHAR_W-1:0] c);
    return {acc[VALUE_W-4:0], 3'b000} + {acc[VALUE_W-2:0], 1'b0}
           + {{(VALUE_W-CHAR_W){1'b0}}, c} - {{(VALUE_W-CHAR_W){1'b0}}, CHAR_ZERO};
  endfunction

  assign skip_count_next = skip_count + 4'd1;

  always_comb begin
    req.a     = first_value;
    req.b     = second_value;
    req.op    = op_code;
    req.ready = (phase == PH_SKIP) || (phase == PH_SECOND);
    req_valid = in_accept && (in_char == CHAR_NUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_START;
      skip_count   <= 4'd0;
      first_value  <= '0;
      second_value <= '0;
      op_code      <= CHAR_NUL;
    end else if (in_accept) begin
      if (in_char == CHAR_NUL) begin
        phase        <= PH_START;
        skip_count   <= 4'd0;
        first_value  <= '0;
        second_value <= '0;
        op_code      <= CHAR_NUL;
      end else begin
        case (phase)
          PH_PREFIX: begin
            skip_count <= skip_count_next;
            if (skip_count_next >= PFX_LEN) begin
              phase <= PH_FIRST;
            end
          end
          PH_FIRST: begin
            if (in_char == CHAR_SPACE) begin
              phase <= PH_OP;
            end else begin
              first_value <= accumulate(first_value, in_char);
            end
          end
          PH_OP: begin
            op_code <= in_char;
            phase   <= PH_SKIP;
          end
          PH_SKIP: begin
            phase <= PH_SECOND;
          end
          PH_SECOND: begin
            second_value <= accumulate(second_value, in_char);
          end
          default: begin
            phase <= PH_PREFIX;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/adec_alu.sv @@
// Arithmetic unit: registered add and subtract, bit-serial multiply and restoring divide.
`default_nettype none

module adec_alu
  import adec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  calc_req_t req,
  output logic      busy,
  output logic      res_valid,
  output emit_req_t res
);

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} astate_t;

  astate_t            state;
  logic [4:0]         cnt;
  logic [VALUE_W-1:0] x;
  logic [VALUE_W-1:0] y;
  logic [VALUE_W:0]   acc;
  logic               neg;

  logic [VALUE_W-1:0] mul_sum;
  logic [VALUE_W:0]   rem_sh;
  logic [VALUE_W:0]   diff;
  logic               qbit;
  logic [VALUE_W:0]   rem_next;
  logic [VALUE_W-1:0] quot_next;

  always_comb begin
    mul_sum   = acc[VALUE_W-1:0] + (y[0] ? x : '0);
    rem_sh    = {acc[VALUE_W-1:0], y[VALUE_W-1]};
    diff      = rem_sh - {1'b0, x};
    qbit      = !diff[VALUE_W];
    rem_next  = qbit ? diff : rem_sh;
    quot_next = {y[VALUE_W-2:0], qbit};
    busy      = (state != A_IDLE) || res_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= A_IDLE;
      res_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      case (state)
        A_IDLE: begin
          if (start) begin
            cnt <= '0;
            acc <= '0;
            if (!req.ready) begin
              res.status <= ST_BADOP;
              res.err    <= 1'b1;
              res.value  <= '0;
              res_valid  <= 1'b1;
            end else begin
              case (req.op)
                CHAR_PLUS: begin
                  res.value  <= req.a + req.b;
                  res.status <= ST_OK;
                  res.err    <= 1'b0;
                  res_valid  <= 1'b1;
                end
                CHAR_MINUS: begin
                  res.value  <= req.a - req.b;
                  res.status <= ST_OK;
                  res.err    <= 1'b0;
                  res_valid  <= 1'b1;
                end
                CHAR_STAR: begin
                  x         <= req.a;
                  y         <= req.b;
                  res_valid <= 1'b0;
                  state     <= A_MUL;
                end
                CHAR_SLASH: begin
                  if (req.b == '0) begin
                    res.status <= ST_DIVZERO;
                    res.err    <= 1'b1;
                    res.value  <= '0;
                    res_valid  <= 1'b1;
                  end else begin
                    x         <= req.b[VALUE_W-1] ? (-req.b) : req.b;
                    y         <= req.a[VALUE_W-1] ? (-req.a) : req.a;
                    neg       <= req.a[VALUE_W-1] ^ req.b[VALUE_W-1];
                    res_valid <= 1'b0;
                    state     <= A_DIV;
                  end
                end
                default: begin
                  res.status <= ST_BADOP;
                  res.err    <= 1'b1;
                  res.value  <= '0;
                  res_valid  <= 1'b1;
                end
              endcase
            end
          end else begin
            res_valid <= 1'b0;
          end
        end
        A_MUL: begin
          acc <= {1'b0, mul_sum};
          x   <= {x[VALUE_W-2:0], 1'b0};
          y   <= {1'b0, y[VALUE_W-1:1]};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            res.value  <= mul_sum;
            res.status <= ST_OK;
            res.err    <= 1'b0;
            res_valid  <= 1'b1;
            state      <= A_IDLE;
          end else begin
            res_valid <= 1'b0;
          end
        end
        A_DIV: begin
          acc <= rem_next;
          y   <= quot_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            res.value  <= neg ? (-quot_next) : quot_next;
            res.status <= ST_OK;
            res.err    <= 1'b0;
            res_valid  <= 1'b1;
            state      <= A_IDLE;
          end else begin
            res_valid <= 1'b0;
          end
        end
        default: begin
          res_valid <= 1'b0;
          state     <= A_IDLE;
        end
      endcase
    end
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == A_IDLE) && !res_valid)
    else $error("Calculation started while the arithmetic unit was busy.");

  a_error_has_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.err |-> res.status != ST_OK)
    else $error("Error result carries an ok status.");

  a_result_ends_work: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> state == A_IDLE)
    else $error("Result issued while the arithmetic unit still works.");

endmodule

`default_nettype wire

@@ hw/rtl/adec_emit.sv @@
// Result formatter: bit-serial binary to decimal conversion and character output register.
`default_nettype none

module adec_emit
  import adec_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  emit_req_t                req,
  output logic                     busy,
  output logic                     m_valid,
  input  wire logic                m_ready,
  output logic [CHAR_W-1:0]        m_char,
  output logic [STATUS_W-1:0]      m_status,
  output logic                     m_last
);

  typedef enum logic [2:0] {E_IDLE, E_CONV, E_TRIM, E_SIGN, E_DIGIT, E_ERR} estate_t;

  localparam int unsigned NDIG = 10;
  localparam int unsigned BCD_W = 4 * NDIG;

  estate_t             state;
  logic [4:0]          cnt;
  logic [VALUE_W-1:0]  mag;
  logic [BCD_W-1:0]    bcd;
  logic [3:0]          digits_left;
  logic                neg;
  logic [STATUS_W-1:0] err_status;
  logic                space;
  logic                load;
  logic [BCD_W-1:0]    bcd_adj;
  logic [3:0]          top_digit;

  function automatic logic [BCD_W-1:0] adjust(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    r = v;
    for (int i = 0; i < NDIG; i++) begin
      if (v[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = v[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  always_comb begin
    space     = !m_valid || m_ready;
    load      = space && ((state == E_SIGN) || (state == E_DIGIT) || (state == E_ERR));
    bcd_adj   = adjust(bcd);
    top_digit = bcd[BCD_W-1 -: 4];
    busy      = (state != E_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= E_IDLE;
      m_valid <= 1'b0;
      cnt     <= '0;
    end else begin
      m_valid <= load || (m_valid && !m_ready);
      case (state)
        E_IDLE: begin
          if (start) begin
            cnt <= '0;
            if (req.err) begin
              err_status <= req.status;
              state      <= E_ERR;
            end else begin
              neg   <= req.value[VALUE_W-1];
              mag   <= req.value[VALUE_W-1] ? (-req.value) : req.value;
              bcd   <= '0;
              state <= E_CONV;
            end
          end
        end
        E_CONV: begin
          bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_W-1]};
          mag <= {mag[VALUE_W-2:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            digits_left <= 4'(NDIG);
            state       <= E_TRIM;
          end
        end
        E_TRIM: begin
          if ((digits_left != 4'd1) && (top_digit == 4'd0)) begin
            bcd         <= {bcd[BCD_W-5:0], 4'd0};
            digits_left <= digits_left - 4'd1;
          end else begin
            state <= neg ? E_SIGN : E_DIGIT;
          end
        end
        E_SIGN: begin
          if (space) begin
            m_char   <= CHAR_MINUS;
            m_status <= ST_OK;
            m_last   <= 1'b0;
            state    <= E_DIGIT;
          end
        end
        E_DIGIT: begin
          if (space) begin
            m_char      <= CHAR_ZERO | {4'd0, top_digit};
            m_status    <= ST_OK;
            m_last      <= (digits_left == 4'd1);
            bcd         <= {bcd[BCD_W-5:0], 4'd0};
            digits_left <= digits_left - 4'd1;
            if (digits_left == 4'd1) begin
              state <= E_IDLE;
            end
          end
        end
        E_ERR: begin
          if (space) begin
            m_char   <= CHAR_NUL;
            m_status <= err_status;
            m_last   <= 1'b1;
            state    <= E_IDLE;
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == E_IDLE)
    else $error("Formatter started while still emitting.");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    m_valid && (m_status != ST_OK) |-> m_last && (m_char == CHAR_NUL))
    else $error("Error transaction is not a single final item.");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    m_valid && (m_status == ST_OK) && (m_char == CHAR_MINUS) |-> !m_last)
    else $error("Minus sign marked as the final character.");

endmodule

`default_nettype wire

@@ hw/rtl/ascii_decimal_expression_calculator_top.sv @@
// Top level of the ASCII decimal expression calculator.
//
// Channel | Direction | tdata            | tuser      | tlast
// s_*     | in        | [7:0] in_char    | -          | -
// m_*     | out       | [7:0] out_char   | [1:0] status | final character
//
// Ordinary characters are taken one per cycle while s_tready is high; each byte is accumulated
// with a multiply by ten, done as shifts and adds, plus the digit. A terminator starts the
// arithmetic: add and subtract are registered directly, multiply and divide run the
// shift-and-add and restoring-divide loop. Binary to decimal conversion and leading-zero
// trimming follow, after which one character leaves per cycle while m_tready is high.
// s_tready is low while a calculation or its formatting is in progress; it returns
// high while the final character may still wait in the output register.
// Reset is synchronous on rst and puts the parser in prefix skip (first operand for no prefix).
`default_nettype none

module ascii_decimal_expression_calculator_top
  import adec_pkg::*;
#(
  parameter int unsigned PREFIX_LEN = PREFIX_LEN_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [CHAR_W-1:0]   s_tdata,   // [7:0] in_char
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [CHAR_W-1:0]        m_tdata,   // [7:0] out_char
  output logic [STATUS_W-1:0]      m_tuser,   // [1:0] status
  output logic                     m_tlast
);

  calc_req_t calc_req;
  logic      calc_start;
  logic      alu_busy;
  logic      res_valid;
  emit_req_t res;
  logic      emit_busy;
  logic      in_accept;

  assign s_tready  = !(alu_busy || emit_busy);
  assign in_accept = s_tvalid && s_tready;

  adec_parse #(
    .PREFIX_LEN(PREFIX_LEN)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_char   (s_tdata),
    .req       (calc_req),
    .req_valid (calc_start)
  );

  adec_alu u_alu (
    .clk       (clk),
    .rst       (rst),
    .start     (calc_start),
    .req       (calc_req),
    .busy      (alu_busy),
    .res_valid (res_valid),
    .res       (res)
  );

  adec_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .start    (res_valid),
    .req      (res),
    .busy     (emit_busy),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_char   (m_tdata),
    .m_status (m_tuser),
    .m_last   (m_tlast)
  );

endmodule

`default_nettype wire

@@ verif/adec_result_checker.sv @@
// Checker that predicts the calculator's output characters and compares every result transaction.
`default_nettype none

module adec_result_checker
  import adec_pkg::*;
#(
  parameter int unsigned PREFIX_LEN = PREFIX_LEN_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  input  wire logic                s_tready,
  input  wire logic [CHAR_W-1:0]   s_tdata,   // [7:0] in_char
  input  wire logic                m_tvalid,
  input  wire logic                m_tready,
  input  wire logic [CHAR_W-1:0]   m_tdata,   // [7:0] out_char
  input  wire logic [STATUS_W-1:0] m_tuser,   // [1:0] status
  input  wire logic                m_tlast,
  output int unsigned              fail_count,
  output int unsigned              outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PARSE_PREFIX,
    PARSE_FIRST,
    PARSE_OP,
    PARSE_SKIP,
    PARSE_SECOND
  } parse_phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   ch;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_char_t;

  localparam logic [3:0] PREFIX_MASKED = 4'(PREFIX_LEN);

  parse_phase_t       phase;
  logic [3:0]         skip_count;
  logic [VALUE_W-1:0] first_value;
  logic [VALUE_W-1:0] second_value;
  logic [CHAR_W-1:0]  op_code;
  result_char_t       pending_chars[$];
  int unsigned        mismatches = 0;

  task automatic parser_reset();
    phase = (PREFIX_MASKED == 4'd0) ? PARSE_FIRST : PARSE_PREFIX;
    skip_count = 4'd0;
    first_value = '0;
    second_value = '0;
    op_code = CHAR_NUL;
  endtask

  function automatic logic [VALUE_W-1:0] shift_in_digit(input logic [VALUE_W-1:0] acc,
                                                        input logic [CHAR_W-1:0] c);
    return acc * 32'd10 + 32'(c) - 32'(CHAR_ZERO);
  endfunction

  task automatic queue_error(input logic [STATUS_W-1:0] status);
    result_char_t rc;
    rc.ch = CHAR_NUL;
    rc.status = status;
    rc.last = 1'b1;
    pending_chars.push_back(rc);
  endtask

  task automatic queue_decimal(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digits[$];
    result_char_t       rc;
    mag = value[VALUE_W-1] ? (32'd0 - value) : value;
    do begin
      digits.push_front(CHAR_ZERO + 8'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    rc.status = ST_OK;
    if (value[VALUE_W-1]) begin
      rc.ch = CHAR_MINUS;
      rc.last = 1'b0;
      pending_chars.push_back(rc);
    end
    foreach (digits[i]) begin
      rc.ch = digits[i];
      rc.last = (i == digits.size() - 1);
      pending_chars.push_back(rc);
    end
  endtask

  task automatic parse_char(input logic [CHAR_W-1:0] c);
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    logic [VALUE_W-1:0] mag_a;
    logic [VALUE_W-1:0] mag_b;
    logic [VALUE_W-1:0] quot;
    logic [CHAR_W-1:0]  op;
    logic               ready;
    if (c == CHAR_NUL) begin
      a = first_value;
      b = second_value;
      op = op_code;
      ready = (phase == PARSE_SKIP) || (phase == PARSE_SECOND);
      parser_reset();
      if (!ready) begin
        queue_error(ST_BADOP);
      end else begin
        case (op)
          CHAR_PLUS:  queue_decimal(a + b);
          CHAR_MINUS: queue_decimal(a - b);
          CHAR_STAR:  queue_decimal(a * b);
          CHAR_SLASH: begin
            if (b == '0) begin
              queue_error(ST_DIVZERO);
            end else begin
              mag_a = a[VALUE_W-1] ? (32'd0 - a) : a;
              mag_b = b[VALUE_W-1] ? (32'd0 - b) : b;
              quot = mag_a / mag_b;
              queue_decimal((a[VALUE_W-1] ^ b[VALUE_W-1]) ? (32'd0 - quot) : quot);
            end
          end
          default: queue_error(ST_BADOP);
        endcase
      end
    end else begin
      case (phase)
        PARSE_PREFIX: begin
          skip_count = skip_count + 4'd1;
          if (skip_count >= PREFIX_MASKED) phase = PARSE_FIRST;
        end
        PARSE_FIRST: begin
          if (c == CHAR_SPACE) phase = PARSE_OP;
          else first_value = shift_in_digit(first_value, c);
        end
        PARSE_OP: begin
          op_code = c;
          phase = PARSE_SKIP;
        end
        PARSE_SKIP: phase = PARSE_SECOND;
        PARSE_SECOND: second_value = shift_in_digit(second_value, c);
        default: phase = PARSE_PREFIX;
      endcase
    end
  endtask

  always @(posedge clk) begin : monitor
    result_char_t got;
    result_char_t want;
    if (rst) begin
      parser_reset();
      pending_chars.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.ch = m_tdata;
        got.status = m_tuser;
        got.last = m_tlast;
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected result transaction: char %h status %0d last %0b",
                   $time, got.ch, got.status, got.last);
          mismatches++;
        end else begin
          want = pending_chars.pop_front();
          if (got.ch !== want.ch || got.status !== want.status || got.last !== want.last) begin
            $display("%0t: expected char %h status %0d last %0b, got char %h status %0d last %0b",
                     $time, want.ch, want.status, want.last, got.ch, got.status, got.last);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) parse_char(s_tdata);
    end
    fail_count <= mismatches;
    outstanding <= pending_chars.size();
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Testbench top that drives command strings into the calculator and gives the verdict.
`default_nettype none

module tb
  import adec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 8;
  localparam int RANDOM_CHARS   = 310;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RX_CALM_CYCLES = 600;
  localparam int QUIET_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 120;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [CHAR_W-1:0]   s_tdata = CHAR_NUL;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [CHAR_W-1:0]   m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic                m_tlast;
  logic                hold_req = 1'b0;
  bit                  tx_calm = 1'b0;
  int unsigned         fail_count;
  int unsigned         outstanding;
  int                  chars_sent = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  ascii_decimal_expression_calculator_top #(
    .PREFIX_LEN(PREFIX_LEN_DEF)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  adec_result_checker #(
    .PREFIX_LEN(PREFIX_LEN_DEF)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  task automatic send_char(input logic [CHAR_W-1:0] c);
    while (!tx_calm && $urandom_range(0, 99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(text[i]);
  endtask

  task automatic send_operand(input int min_len);
    int len;
    int pick;
    len = ($urandom_range(0, 9) < 7) ? $urandom_range(min_len, 3) : $urandom_range(min_len, 10);
    repeat (len) begin
      pick = $urandom_range(0, 19);
      if (pick < 18) send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
      else if (pick == 18) send_char(CHAR_SLASH);
      else send_char(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic send_random_command();
    logic [CHAR_W-1:0] ops[4] = '{CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH};
    int shape;
    int pick;
    shape = $urandom_range(0, 99);
    if (shape < 10) begin
      repeat ($urandom_range(0, 12)) send_char(8'($urandom_range(1, 255)));
    end else begin
      repeat (PREFIX_LEN_DEF) send_char(8'($urandom_range(1, 255)));
      send_operand(1);
      if (shape < 18) begin
        // A command cut short before its operator has been seen.
        if (shape < 14) send_char(CHAR_SPACE);
      end else begin
        send_char(CHAR_SPACE);
        pick = $urandom_range(0, 19);
        send_char(pick < 18 ? ops[pick % 4] : 8'($urandom_range(1, 255)));
        send_char(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 9) != 0) send_operand(0);
      end
    end
    send_char(CHAR_NUL);
  endtask

  initial begin : stimulus
    int first_random;
    int cmd_idx;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_char(CHAR_NUL);
    send_char(8'hff);
    send_char(8'h01);
    send_char(8'h80);
    send_char(8'h7f);
    send_char(CHAR_SPACE);
    send_text("7 /");
    send_char(CHAR_NUL);
    // The most negative value divided by minus one wraps back to itself.
    send_text("calc 2147483648 / /");
    send_char(CHAR_NUL);

    first_random = chars_sent;
    cmd_idx = 0;
    while (chars_sent < first_random + RANDOM_CHARS) begin
      tx_calm = (cmd_idx >= 6 && cmd_idx < 11);
      if (cmd_idx == 2) hold_req <= 1'b1;
      send_random_command();
      cmd_idx++;
    end
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ascii_decimal_expression_calculator_top: match");
    end else begin
      $display("ascii_decimal_expression_calculator_top: mismatch");
    end
    $finish;
  end

  initial begin : result_sink
    bit hold_done;
    int calm_left;
    hold_done = 1'b0;
    calm_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        // Long back-pressure so that the calculator fills up and stalls its input.
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
        calm_left = RX_CALM_CYCLES;
      end else if (calm_left > 0) begin
        calm_left--;
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("ascii_decimal_expression_calculator_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/adec_pkg.sv
hw/rtl/adec_parse.sv
hw/rtl/adec_alu.sv
hw/rtl/adec_emit.sv
hw/rtl/ascii_decimal_expression_calculator_top.sv
verif/adec_result_checker.sv
verif/tb.sv
